>>> src/tfr_pkg.sv
// shared types and constants for the touch frame receiver
package tfr_pkg;

  localparam logic [7:0] SigByte     = 8'h2E;
  localparam logic [7:0] TouchCmdRst = 8'h20;
  localparam logic [7:0] TouchMinLen = 8'd5;
  localparam int unsigned TouchBytes = 5;
  localparam int unsigned TbIdxW     = $clog2(TouchBytes);

  localparam logic [2:0] PhHunt    = 3'd0;
  localparam logic [2:0] PhCmd     = 3'd1;
  localparam logic [2:0] PhLen     = 3'd2;
  localparam logic [2:0] PhPayload = 3'd3;
  localparam logic [2:0] PhCheck   = 3'd4;

  typedef struct packed {
    logic        frame_ok;
    logic [7:0]  frame_cmd;
    logic [7:0]  frame_len;
    logic        touch_updated;
    logic        pressed;
    logic [15:0] pos_x;
    logic [15:0] pos_y;
  } res_t;

endpackage

>>> src/tfr_parser.sv
// frame parser: phase tracking, checksum, touch payload capture and touch state
module tfr_parser import tfr_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       step_i,
  input  logic [7:0] byte_i,
  input  logic [7:0] touch_cmd_i,
  output logic       res_valid_o,
  output res_t       res_o
);

  logic [2:0]  phase_q, phase_d;
  logic [7:0]  cmd_q, cmd_d;
  logic [7:0]  len_q, len_d;
  logic [7:0]  count_q, count_d;
  logic [7:0]  sum_q, sum_d;
  logic        pressed_q, pressed_d;
  logic [15:0] x_q, x_d;
  logic [15:0] y_q, y_d;
  logic [7:0]  tbytes_q [TouchBytes];

  logic        tb_we;
  logic [7:0]  sum_add;
  logic [7:0]  count_inc;
  logic        chk_ok;
  logic        upd;
  logic        all_zero;

  assign sum_add   = sum_q + byte_i;
  assign count_inc = count_q + 8'd1;
  assign chk_ok    = (~sum_q == byte_i);
  assign upd       = chk_ok && (cmd_q == touch_cmd_i) && (len_q >= TouchMinLen);
  assign all_zero  = ((tbytes_q[0] | tbytes_q[1] | tbytes_q[2] | tbytes_q[3] |
                       tbytes_q[4]) == 8'd0);

  always_comb begin
    phase_d     = phase_q;
    cmd_d       = cmd_q;
    len_d       = len_q;
    count_d     = count_q;
    sum_d       = sum_q;
    pressed_d   = pressed_q;
    x_d         = x_q;
    y_d         = y_q;
    tb_we       = 1'b0;
    res_valid_o = 1'b0;
    unique case (phase_q)
      PhHunt: begin
        if (byte_i == SigByte) phase_d = PhCmd;
      end
      PhCmd: begin
        cmd_d   = byte_i;
        sum_d   = byte_i;
        phase_d = PhLen;
      end
      PhLen: begin
        len_d   = byte_i;
        sum_d   = sum_add;
        count_d = 8'd0;
        phase_d = (byte_i == 8'd0) ? PhCheck : PhPayload;
      end
      PhPayload: begin
        tb_we   = (count_q < TouchMinLen);
        sum_d   = sum_add;
        count_d = count_inc;
        if (count_inc == len_q) phase_d = PhCheck;
      end
      default: begin
        // checksum beat closes the frame
        res_valid_o = 1'b1;
        phase_d     = PhHunt;
        if (upd) begin
          if (all_zero) begin
            pressed_d = 1'b0;
          end else begin
            pressed_d = 1'b1;
            x_d       = {tbytes_q[1], tbytes_q[0]};
            y_d       = {tbytes_q[3], tbytes_q[2]};
          end
        end
      end
    endcase
  end

  always_comb begin
    res_o.frame_ok      = chk_ok;
    res_o.frame_cmd     = cmd_q;
    res_o.frame_len     = len_q;
    res_o.touch_updated = upd;
    res_o.pressed       = pressed_d;
    res_o.pos_x         = x_d;
    res_o.pos_y         = y_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PhHunt;
      cmd_q     <= 8'd0;
      len_q     <= 8'd0;
      count_q   <= 8'd0;
      sum_q     <= 8'd0;
      pressed_q <= 1'b0;
      x_q       <= 16'd0;
      y_q       <= 16'd0;
    end else if (step_i) begin
      phase_q   <= phase_d;
      cmd_q     <= cmd_d;
      len_q     <= len_d;
      count_q   <= count_d;
      sum_q     <= sum_d;
      pressed_q <= pressed_d;
      x_q       <= x_d;
      y_q       <= y_d;
    end
  end

  // payload capture, only the first five bytes are kept
  always_ff @(posedge clk_i) begin
    if (step_i && tb_we) begin
      tbytes_q[count_q[TbIdxW-1:0]] <= byte_i;
    end
  end

endmodule

>>> src/tfr_out_reg.sv
// result register holding one frame status beat until the sink takes it
module tfr_out_reg import tfr_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic load_i,
  input  res_t res_i,
  input  logic stall_i,
  output logic free_o,
  output logic valid_o,
  output res_t res_o
);

  logic valid_q, valid_d;
  res_t res_q;

  assign free_o  = !valid_q || !stall_i;
  assign valid_d = load_i ? 1'b1 : (valid_q && stall_i);
  assign valid_o = valid_q;
  assign res_o   = res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= res_i;
    end
  end

endmodule

>>> src/touch_frame_receiver.sv
// touch frame receiver: byte in, frame status out, two register stages
// a taken byte goes into the input register; a frame result goes on into the result register
// throughput: one byte per cycle; the input register stalls only while the
// result register holds an untaken beat
// reset: async active low; hunting for signature, touch state released at 0,0,
// touch command register 0x20
module touch_frame_receiver import tfr_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [7:0]  cfg_data_i,
  input  logic        rx_valid_i,
  output logic        rx_stall_o,
  input  logic [7:0]  rx_byte_i,
  output logic        frame_valid_o,
  input  logic        frame_stall_i,
  output logic        frame_ok_o,
  output logic [7:0]  frame_cmd_o,
  output logic [7:0]  frame_len_o,
  output logic        touch_updated_o,
  output logic        pressed_o,
  output logic [15:0] pos_x_o,
  output logic [15:0] pos_y_o
);

  logic       in_valid_q, in_valid_d;
  logic [7:0] in_byte_q;
  logic [7:0] touch_cmd_q;
  logic       out_free;
  logic       step;
  logic       res_valid;
  logic       rx_take;
  res_t       res;
  res_t       out_res;

  assign cfg_ready_o = 1'b1;
  assign step        = in_valid_q && out_free;
  assign rx_stall_o  = in_valid_q && !out_free;
  assign rx_take     = rx_valid_i && !rx_stall_o;
  assign in_valid_d  = rx_take ? 1'b1 : (in_valid_q && !step);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      touch_cmd_q <= TouchCmdRst;
    end else begin
      in_valid_q <= in_valid_d;
      if (cfg_valid_i && cfg_ready_o) touch_cmd_q <= cfg_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rx_take) in_byte_q <= rx_byte_i;
  end

  tfr_parser u_parser (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .step_i     (step),
    .byte_i     (in_byte_q),
    .touch_cmd_i(touch_cmd_q),
    .res_valid_o(res_valid),
    .res_o      (res)
  );

  tfr_out_reg u_out (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .load_i (step && res_valid),
    .res_i  (res),
    .stall_i(frame_stall_i),
    .free_o (out_free),
    .valid_o(frame_valid_o),
    .res_o  (out_res)
  );

  assign frame_ok_o      = out_res.frame_ok;
  assign frame_cmd_o     = out_res.frame_cmd;
  assign frame_len_o     = out_res.frame_len;
  assign touch_updated_o = out_res.touch_updated;
  assign pressed_o       = out_res.pressed;
  assign pos_x_o         = out_res.pos_x;
  assign pos_y_o         = out_res.pos_y;

  a_upd_needs_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    frame_valid_o && touch_updated_o |-> frame_ok_o && (frame_len_o >= TouchMinLen))
    else $error("touch update on a bad or short frame");

  a_stall_only_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rx_stall_o |-> in_valid_q && frame_valid_o && frame_stall_i)
    else $error("input stalled with a free result register");

  a_result_from_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(frame_valid_o) |-> $past(in_valid_q))
    else $error("result beat without a byte in the input register");

  a_taken_byte_moves: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_q && !frame_valid_o |=> !$past(rx_stall_o))
    else $error("byte held although the result register was empty");

endmodule
